// File: src/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CharW   = 7;
    localparam int unsigned SextetW = 6;
    localparam int unsigned GroupW  = 3 * ByteW;

    typedef logic [ByteW-1:0]   t_byte;
    typedef logic [CharW-1:0]   t_char;
    typedef logic [SextetW-1:0] t_sextet;
    typedef logic [GroupW-1:0]  t_group;
    typedef logic [1:0]         t_count;

    localparam t_count CntEmpty = 2'd0;
    localparam t_count CntOne   = 2'd1;
    localparam t_count CntTwo   = 2'd2;
    localparam t_count CntLast  = 2'd3;

    localparam t_char ChUpperA = 7'd65;
    localparam t_char ChLowerA = 7'd97;
    localparam t_char ChZero   = 7'd48;
    localparam t_char ChPlus   = 7'd43;
    localparam t_char ChSlash  = 7'd47;

    // Maps a six-bit value onto the standard alphabet.
    function automatic t_char sextet_to_char(input t_sextet v);
        t_char c;
        c = {1'b0, v};
        if (v < 6'd26) begin
            sextet_to_char = ChUpperA + c;
        end else if (v < 6'd52) begin
            sextet_to_char = ChLowerA + c - 7'd26;
        end else if (v < 6'd62) begin
            sextet_to_char = ChZero + c - 7'd52;
        end else if (v == 6'd62) begin
            sextet_to_char = ChPlus;
        end else begin
            sextet_to_char = ChSlash;
        end
    endfunction

endpackage

`default_nettype wire

// File: src/base64_byte_encoder.sv
// Unpadded base64 encoder, one message byte per input word.
// Input channel: i_valid/o_ready carry i_data_byte and i_final_byte, the
// latter set on the last byte of a message. Output channel: o_valid/i_ready
// carry o_code_char (ASCII) and o_group_end, set on the fourth character of
// each group of four.
// Bytes that neither complete a group of three nor end the message are
// stored and accepted in every cycle. A completing byte is packed into a
// group buffer in the cycle it is accepted; a short final group is filled
// with zero bytes and never padded with '='.
// The completing byte's group passes through the group buffer and then the
// output register; one character leaves per cycle while the receiver is ready.
// The single group buffer sets the sustained rate: a new group can be loaded
// only as the last character of the previous one moves to the output register.
// When the receiver stalls, the output register holds its word and the group
// buffer fills; o_ready then drops only for a byte that would complete the
// next group.
// Synchronous reset clears the pending byte count, the group buffer and the
// output register; no word is presented right after reset.
`default_nettype none

module base64_byte_encoder
    import b64e_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_byte i_data_byte,
    input  wire logic  i_final_byte,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_char      o_code_char,
    output logic       o_group_end
);

    t_count r_cnt, n_cnt;
    t_byte  r_first;
    t_byte  r_second;
    logic   completes;
    logic   grp_free;
    logic   accept;
    logic   load;
    t_group group;

    assign completes = i_final_byte || (r_cnt == CntTwo) || (r_cnt == CntLast);
    assign o_ready   = grp_free || !completes;
    assign accept    = i_valid && o_ready;
    assign load      = accept && completes;

    always_comb begin
        priority if (r_cnt == CntEmpty) begin
            group = {i_data_byte, 16'h0000};
        end else if (r_cnt == CntOne) begin
            group = {r_first, i_data_byte, 8'h00};
        end else begin
            group = {r_first, r_second, i_data_byte};
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            if (completes) begin
                n_cnt = CntEmpty;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CntEmpty;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !completes) begin
            if (r_cnt == CntEmpty) begin
                r_first <= i_data_byte;
            end else begin
                r_second <= i_data_byte;
            end
        end
    end

    b64e_serializer u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_group     (group),
        .o_free      (grp_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_char (o_code_char),
        .o_group_end (o_group_end)
    );

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != CntLast)
        else $error("Pending byte count reached three.");

    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_cnt == CntEmpty))
        else $error("Pending byte count not cleared after a group was emitted.");

    a_pending_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !completes) |-> o_ready)
        else $error("A byte that completes no group was held off.");

endmodule

`default_nettype wire

// File: src/b64e_serializer.sv
`default_nettype none

module b64e_serializer
    import b64e_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_group i_group,
    output logic        o_free,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_char       o_code_char,
    output logic        o_group_end
);

    logic   r_grp_vld, n_grp_vld;
    t_group r_grp;
    t_count r_idx, n_idx;
    logic   r_out_vld, n_out_vld;
    t_char  r_out_char;
    logic   r_out_end;
    logic   out_free;
    logic   advance;
    t_sextet sextet;

    assign out_free = !r_out_vld || i_ready;
    assign advance  = r_grp_vld && out_free;
    assign o_free   = !r_grp_vld || (advance && (r_idx == CntLast));

    always_comb begin
        unique case (r_idx)
            CntEmpty: sextet = r_grp[23:18];
            CntOne:   sextet = r_grp[17:12];
            CntTwo:   sextet = r_grp[11:6];
            CntLast:  sextet = r_grp[5:0];
            default:  sextet = r_grp[5:0];
        endcase
    end

    always_comb begin
        n_grp_vld = r_grp_vld;
        n_idx     = r_idx;
        n_out_vld = r_out_vld;
        if (advance) begin
            n_idx     = r_idx + 2'd1;
            n_out_vld = 1'b1;
            if (r_idx == CntLast) begin
                n_grp_vld = 1'b0;
            end
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
        if (i_load) begin
            n_grp_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
            r_idx     <= CntEmpty;
            r_out_vld <= 1'b0;
        end else begin
            r_grp_vld <= n_grp_vld;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
        if (advance) begin
            r_out_char <= sextet_to_char(sextet);
            r_out_end  <= (r_idx == CntLast);
        end
    end

    assign o_valid     = r_out_vld;
    assign o_code_char = r_out_char;
    assign o_group_end = r_out_end;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("Group loaded while the buffer was busy.");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_grp_vld |-> (r_idx == CntEmpty))
        else $error("Character index not at zero while no group is held.");

    a_end_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_idx == CntLast)) |=> (r_out_vld && r_out_end))
        else $error("Fourth character of a group was not marked.");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top
    import b64e_pkg::*;
;

    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned RandomBytes  = 160;
    localparam int unsigned HoldAfter    = 40;
    localparam int unsigned HoldCycles   = 200;
    localparam int unsigned TailCycles   = 20;
    localparam int unsigned MaxIdle      = 14;
    localparam int unsigned CharsPerGrp  = 4;

    localparam logic [64*ByteW-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct {
        t_byte       data;
        logic        last;
        int unsigned gap;
        bit          drain;
    } t_msg_byte;

    typedef struct {
        t_char code;
        logic  group_end;
    } t_code_word;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_valid      = 1'b0;
    logic  o_ready;
    t_byte i_data_byte  = '0;
    logic  i_final_byte = 1'b0;
    logic  o_valid;
    logic  i_ready      = 1'b0;
    t_char o_code_char;
    logic  o_group_end;

    base64_byte_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_char  (o_code_char),
        .o_group_end  (o_group_end)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_msg_byte   byte_queue[$];
    t_code_word  char_queue[$];

    t_byte       held_first  = '0;
    t_byte       held_second = '0;
    t_count      held_count  = CntEmpty;

    int unsigned cycle_count = 0;
    int unsigned chars_due   = 0;
    int unsigned chars_seen  = 0;
    int unsigned mismatches  = 0;
    int unsigned msg_count   = 0;
    int unsigned idle_left   = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_next;
    int unsigned new_chars;
    bit          tx_burst    = 1'b0;
    bit          rx_calm     = 1'b0;
    bit          drain_next  = 1'b0;
    t_msg_byte   next_byte;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Bytes collect into groups of three; a completing or final byte turns the
    // open group (zero filled) into four characters.
    task automatic encode_byte(input t_byte b, input logic fin, output int unsigned n);
        t_group  grp;
        t_sextet sx;
        int      k;
        n = 0;
        if (held_count < CntTwo && !fin) begin
            if (held_count == CntEmpty) begin
                held_first = b;
            end else begin
                held_second = b;
            end
            held_count = held_count + 1'b1;
        end else begin
            case (held_count)
                CntEmpty: grp = {b, {2*ByteW{1'b0}}};
                CntOne:   grp = {held_first, b, {ByteW{1'b0}}};
                default:  grp = {held_first, held_second, b};
            endcase
            for (k = 0; k < CharsPerGrp; k++) begin
                sx = grp[GroupW-1-SextetW*k -: SextetW];
                char_queue.push_back('{code: Alphabet[ByteW*(63-sx) +: CharW],
                                       group_end: (k == CharsPerGrp-1)});
            end
            held_first  = '0;
            held_second = '0;
            held_count  = CntEmpty;
            n = CharsPerGrp;
        end
    endtask

    task automatic add_byte(input t_byte b, input logic fin);
        byte_queue.push_back('{data: b, last: fin,
                               gap: tx_burst ? 0 : $urandom_range(0, MaxIdle),
                               drain: drain_next});
        drain_next = 1'b0;
        if (fin) begin
            msg_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            idle_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                encode_byte(i_data_byte, i_final_byte, new_chars);
                chars_due <= chars_due + new_chars;
            end
            if (idle_left != 0) begin
                idle_left <= idle_left - 1;
                i_valid   <= 1'b0;
            end else if (byte_queue.size() != 0 &&
                         !(byte_queue[0].drain && (i_valid || chars_seen != chars_due))) begin
                next_byte    = byte_queue.pop_front();
                i_data_byte  <= next_byte.data;
                i_final_byte <= next_byte.last;
                i_valid      <= 1'b1;
                idle_left    <= (byte_queue.size() != 0) ? byte_queue[0].gap : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic check_word(input t_char c, input logic ge);
        t_code_word want;
        if (char_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word char=%0d end=%0b", c, ge));
        end else begin
            want = char_queue.pop_front();
            if (c != want.code) begin
                report_mismatch($sformatf("char %0d, expected %0d", c, want.code));
            end
            if (ge != want.group_end) begin
                report_mismatch($sformatf("group end %0b, expected %0b", ge, want.group_end));
            end
        end
    endtask

    // The receiver waits a drawn number of cycles after each word, and once
    // holds off for a long stretch so that the encoder backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                check_word(o_code_char, o_group_end);
                chars_seen <= chars_seen + 1;
                if (chars_seen + 1 == HoldAfter) begin
                    stall_next = HoldCycles;
                end else begin
                    stall_next = rx_calm ? 0 : $urandom_range(0, MaxIdle);
                end
                if ($urandom_range(0, 19) == 0) begin
                    rx_calm <= ~rx_calm;
                end
            end else if (stall_left != 0) begin
                stall_next = stall_left - 1;
            end else begin
                stall_next = 0;
            end
            stall_left <= stall_next;
            i_ready    <= (stall_next == 0);
        end
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
        end
        $display("FAIL base64_byte_encoder");
        $finish;
    end

    initial begin
        int unsigned random_bytes;
        int unsigned msg_len;
        int unsigned n;
        bit          broken;
        t_byte       b;

        random_bytes = 0;

        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFB, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBE, 1'b1);
        add_byte(8'h4D, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h6E, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b1);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h3C, 1'b1);

        drain_next = 1'b1;
        while (random_bytes < RandomBytes) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                drain_next = 1'b1;
            end
            msg_len = $urandom_range(1, 9);
            broken  = ($urandom_range(0, 6) == 0);
            for (n = 0; n < msg_len; n++) begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = t_byte'($urandom);
                endcase
                add_byte(b, broken ? ($urandom_range(0, 2) == 0) : (n == msg_len - 1));
                random_bytes++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (chars_seen != chars_due) begin
            @(posedge i_clk);
        end
        repeat (TailCycles) @(posedge i_clk);

        $display("Encoded %0d random and 22 directed bytes (%0d ended messages), %0d chars.",
                 random_bytes, msg_count, chars_seen);
        $display("Receiver held off %0d cycles once; sender drained before some messages.",
                 HoldCycles);
        if (mismatches == 0) begin
            $display("PASS base64_byte_encoder");
        end else begin
            $display("FAIL base64_byte_encoder");
        end
        $finish;
    end

endmodule

`default_nettype wire
